// ----- rtl/core/skewed_gauss_lattice_reduce_core_macros.svh -----
// Assertion macros for the lattice reduction core.
`ifndef SKEWED_GAUSS_LATTICE_REDUCE_CORE_MACROS_SVH
`define SKEWED_GAUSS_LATTICE_REDUCE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SGLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SGLR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SGLR_ASSERT(lbl, prop, msg)
`define SGLR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/sglr_pkg.sv -----
package sglr_pkg;

    localparam int LOG_REGION = 16;
    localparam int MAX_ROUNDS = 128;

    localparam int WW      = 256;
    localparam int VW      = 80;
    localparam int YW      = VW + 1;
    localparam int SH_W    = 23;
    localparam int JW      = LOG_REGION;
    localparam int LINES_W = LOG_REGION + 7;
    localparam int PW      = 64 + JW;
    localparam int PR_W    = JW + 1 + LINES_W;
    localparam int DIV_CW  = $clog2(WW) + 1;
    localparam int RC_W    = $clog2(MAX_ROUNDS);
    localparam int LOGI_W  = 5;

    localparam logic [SH_W-1:0] SH_MAX = {SH_W{1'b1}};

    localparam logic [1:0] CFG_SKEW    = 2'd0;
    localparam logic [1:0] CFG_BOUND   = 2'd1;
    localparam logic [1:0] CFG_LOGI    = 2'd2;
    localparam logic [1:0] CFG_THREADS = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD,
        OP_MUL_AA, OP_MUL_BB, OP_MUL_TSN, OP_MUL_VAA, OP_MUL_VBB, OP_MUL_TSD,
        OP_DIV_Q, OP_RND1, OP_RND2, OP_MUL_KA, OP_MUL_KB,
        OP_FIT, OP_M0, OP_M1, OP_SWP, OP_JPRE, OP_JP2, OP_DIV_J, OP_JQ,
        OP_LINES, OP_DIV_L, OP_JMUL, OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic dir;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic stop;
        logic ovf;
        logic scale;
        logic jpos;
        logic out_busy;
    } st_t;

    function automatic logic fits_w(input logic [WW-1:0] x, input int bits);
        logic [WW-1:0] h;
        h = WW'($signed(x) >>> (bits - 1));
        return (&h) | (~|h);
    endfunction

    function automatic logic fits32(input logic [VW-1:0] x);
        logic [VW-1:0] h;
        h = VW'($signed(x) >>> 31);
        return (&h) | (~|h);
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? 32'(32'd0 - x) : x;
    endfunction

endpackage

// ----- rtl/core/sglr_mul.sv -----
module sglr_mul
    import sglr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WW-1:0]        x,
    input  logic signed [YW-1:0] y,
    output logic [WW-1:0]        p,
    output logic                 busy,
    output logic                 done
);

    logic [WW-1:0] acc_reg;
    logic [WW-1:0] xs_reg;
    logic [YW-1:0] ym_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && ym_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            xs_reg  <= x;
            ym_reg  <= y[YW-1] ? YW'(-y) : YW'(y);
            neg_reg <= y[YW-1];
        end
        else if (busy_reg)
        begin
            if (ym_reg == '0)
            begin
                acc_reg <= neg_reg ? WW'(-acc_reg) : acc_reg;
            end
            else
            begin
                if (ym_reg[0])
                begin
                    acc_reg <= WW'(acc_reg + xs_reg);
                end
                xs_reg <= {xs_reg[WW-2:0], 1'b0};
                ym_reg <= {1'b0, ym_reg[YW-1:1]};
            end
        end
    end

    assign p    = acc_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- rtl/core/sglr_div.sv -----
module sglr_div
    import sglr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [WW-1:0] n,
    input  logic [WW-1:0] d,
    output logic [WW-1:0] q,
    output logic [WW-1:0] r,
    output logic          busy,
    output logic          done
);

    logic [WW-1:0]     n_reg;
    logic [WW-1:0]     d_reg;
    logic [WW-1:0]     q_reg;
    logic [WW-1:0]     r_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WW:0]       rs;
    logic              ge;

    assign rs = {r_reg, n_reg[WW-1]};
    assign ge = rs >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(WW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= DIV_CW'(cnt_reg - 1'b1);
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= n;
            d_reg <= d;
            q_reg <= '0;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[WW-2:0], 1'b0};
            q_reg <= {q_reg[WW-2:0], ge};
            r_reg <= ge ? WW'(rs - {1'b0, d_reg}) : rs[WW-1:0];
        end
    end

    assign q    = q_reg;
    assign r    = r_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- rtl/core/sglr_dp.sv -----
module sglr_dp
    import sglr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [52:0]         special_q,
    input  logic [52:0]         root_rho,
    input  cmd_t                cmd,
    output st_t                 st,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [31:0]  first_a,
    output logic signed [31:0]  first_b,
    output logic signed [31:0]  second_a,
    output logic signed [31:0]  second_b,
    output logic [SH_W-1:0]     sieve_height,
    output logic                overflow
);

    logic [31:0]         skew_reg;
    logic [31:0]         nb_reg;
    logic [4:0]          lsw_reg;
    logic [6:0]          tc_reg;

    logic signed [VW-1:0] v0a_reg, v0b_reg, v1a_reg, v1b_reg;
    logic signed [VW-1:0] ua, ub, va, vb;
    logic [63:0]         ss_reg;
    logic [WW-1:0]       acc_reg, tmp_reg, num_reg, den_reg, qr_reg;
    logic                nneg_reg, dbad_reg;
    logic [63:0]         k_reg;
    logic                stop_reg, ovf_reg, scale_reg, out_valid_reg;
    op_t                 pend_reg;

    logic [31:0]         ea0_reg, eb0_reg, ea1_reg, eb1_reg;
    logic [63:0]         m0_reg, m1_reg, pn_reg;
    logic [LOGI_W-1:0]   logi_reg;
    logic [JW-1:0]       half_reg, j_reg;
    logic [PW-1:0]       p_reg;
    logic [LINES_W-1:0]  lines_reg;
    logic [SH_W-1:0]     h_reg;

    logic [31:0]         fa_reg, fb_reg, sa_reg, sb_reg;
    logic [SH_W-1:0]     sh_reg;
    logic                of_reg;

    logic                mul_start, mul_busy, mul_done;
    logic [WW-1:0]       mul_x, mul_p;
    logic signed [YW-1:0] mul_y;
    logic                div_start, div_busy, div_done;
    logic [WW-1:0]       div_n, div_d, div_q, div_r;

    logic [31:0]         mm_a, mm_b;
    logic [63:0]         mm_p;
    logic [WW-1:0]       diff;
    logic [WW+1:0]       r2;
    logic                rup;
    logic [WW-1:0]       qs;
    logic [63:0]         msh, mbig;
    logic [LOGI_W-1:0]   logi_c;
    logic [JW:0]         qp1;
    logic [PR_W-1:0]     prod2;

    assign ua = cmd.dir ? v1a_reg : v0a_reg;
    assign ub = cmd.dir ? v1b_reg : v0b_reg;
    assign va = cmd.dir ? v0a_reg : v1a_reg;
    assign vb = cmd.dir ? v0b_reg : v1b_reg;

    always_comb
    begin
        mul_start = 1'b1;
        mul_x     = {{(WW-VW){ua[VW-1]}}, ua};
        mul_y     = {{(YW-VW){va[VW-1]}}, va};
        unique case (cmd.op)
            OP_MUL_AA: ;
            OP_MUL_BB:
            begin
                mul_x = {{(WW-VW){ub[VW-1]}}, ub};
                mul_y = {{(YW-VW){vb[VW-1]}}, vb};
            end
            OP_MUL_TSN, OP_MUL_TSD:
            begin
                mul_x = tmp_reg;
                mul_y = {{(YW-64){1'b0}}, ss_reg};
            end
            OP_MUL_VAA:
            begin
                mul_x = {{(WW-VW){va[VW-1]}}, va};
            end
            OP_MUL_VBB:
            begin
                mul_x = {{(WW-VW){vb[VW-1]}}, vb};
                mul_y = {{(YW-VW){vb[VW-1]}}, vb};
            end
            OP_MUL_KA:
            begin
                mul_x = {{(WW-VW){va[VW-1]}}, va};
                mul_y = {{(YW-64){k_reg[63]}}, k_reg};
            end
            OP_MUL_KB:
            begin
                mul_x = {{(WW-VW){vb[VW-1]}}, vb};
                mul_y = {{(YW-64){k_reg[63]}}, k_reg};
            end
            default: mul_start = 1'b0;
        endcase
    end

    always_comb
    begin
        div_start = 1'b1;
        div_n     = num_reg[WW-1] ? WW'(-num_reg) : num_reg;
        div_d     = den_reg;
        unique case (cmd.op)
            OP_DIV_Q: ;
            OP_DIV_J:
            begin
                div_n = WW'(p_reg);
                div_d = WW'(m1_reg);
            end
            OP_DIV_L:
            begin
                div_n = WW'(JW'(j_reg - JW'(1)));
                div_d = WW'(lines_reg);
            end
            default: div_start = 1'b0;
        endcase
    end

    always_comb
    begin
        mm_a = skew_reg;
        mm_b = skew_reg;
        unique case (cmd.op)
            OP_M0:   mm_a = mag32(eb0_reg);
            OP_M1:   mm_a = mag32(eb1_reg);
            OP_JPRE: mm_a = nb_reg;
            default: ;
        endcase
    end
    assign mm_p = 64'(mm_a) * 64'(mm_b);

    sglr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .p     (mul_p),
        .busy  (mul_busy),
        .done  (mul_done)
    );

    sglr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .q     (div_q),
        .r     (div_r),
        .busy  (div_busy),
        .done  (div_done)
    );

    assign diff = (pend_reg == OP_MUL_KA)
                ? WW'({{(WW-VW){ua[VW-1]}}, ua} - mul_p)
                : WW'({{(WW-VW){ub[VW-1]}}, ub} - mul_p);
    assign r2   = {1'b0, div_r, 1'b0};
    assign rup  = (r2 > {2'b0, den_reg}) || ((r2 == {2'b0, den_reg}) && div_q[0]);
    assign qs   = nneg_reg ? WW'(-qr_reg) : qr_reg;
    assign msh  = {16'd0, mag32((cmd.op == OP_M0) ? ea0_reg : ea1_reg), 16'd0};
    assign mbig = (mm_p > msh) ? mm_p : msh;
    assign logi_c = (lsw_reg > LOGI_W'(LOG_REGION)) ? LOGI_W'(LOG_REGION) : lsw_reg;
    assign qp1  = (JW+1)'({1'b0, div_q[JW-1:0]} + 1'b1);
    assign prod2 = PR_W'(qp1) * PR_W'(lines_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skew_reg      <= 32'd65536;
            nb_reg        <= 32'd1048576;
            lsw_reg       <= 5'd11;
            tc_reg        <= 7'd1;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            scale_reg     <= 1'b0;
            pend_reg      <= OP_NONE;
            j_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SKEW:    skew_reg <= cfg_data;
                    CFG_BOUND:   nb_reg   <= cfg_data;
                    CFG_LOGI:    lsw_reg  <= cfg_data[4:0];
                    CFG_THREADS: tc_reg   <= cfg_data[6:0];
                endcase
            end
            if (mul_start)
            begin
                pend_reg <= cmd.op;
            end
            if (mul_done && (pend_reg == OP_MUL_KA || pend_reg == OP_MUL_KB)
                && !fits_w(diff, VW))
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    ovf_reg  <= 1'b0;
                    stop_reg <= 1'b0;
                end
                OP_RND2:
                begin
                    if (dbad_reg)
                    begin
                        stop_reg <= 1'b1;
                    end
                    else
                    begin
                        stop_reg <= !fits_w(qs, 64) || qs[63:0] == 64'd0;
                        if (!fits_w(qs, 64))
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                OP_FIT:
                begin
                    if (!(fits32(v0a_reg) && fits32(v0b_reg) &&
                          fits32(v1a_reg) && fits32(v1b_reg)))
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_JPRE:
                begin
                    scale_reg <= (m1_reg != 64'd0) && (m1_reg >= {16'd0, nb_reg, 16'd0});
                    j_reg     <= (logi_c == '0) ? JW'(0) : JW'(JW'(1) << (logi_c - 1'b1));
                end
                OP_JQ:
                begin
                    j_reg <= (div_q > WW'(half_reg)) ? half_reg : div_q[JW-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            unique case (pend_reg)
                OP_MUL_AA, OP_MUL_VAA: acc_reg <= {mul_p[WW-33:0], 32'd0};
                OP_MUL_BB, OP_MUL_VBB: tmp_reg <= mul_p;
                OP_MUL_TSN:            num_reg <= WW'(acc_reg + mul_p);
                OP_MUL_TSD:            den_reg <= WW'(acc_reg + mul_p);
                OP_MUL_KA:
                begin
                    if (cmd.dir) v1a_reg <= diff[VW-1:0];
                    else         v0a_reg <= diff[VW-1:0];
                end
                OP_MUL_KB:
                begin
                    if (cmd.dir) v1b_reg <= diff[VW-1:0];
                    else         v0b_reg <= diff[VW-1:0];
                end
                default: ;
            endcase
        end
        unique case (cmd.op)
            OP_LOAD:
            begin
                v0a_reg <= VW'(special_q);
                v0b_reg <= '0;
                v1a_reg <= VW'(root_rho);
                v1b_reg <= VW'(1);
                ss_reg  <= mm_p;
            end
            OP_DIV_Q:
            begin
                nneg_reg <= num_reg[WW-1];
                dbad_reg <= (den_reg == '0) || den_reg[WW-1];
            end
            OP_RND1: qr_reg <= WW'(div_q + WW'(rup));
            OP_RND2: k_reg  <= dbad_reg ? 64'd0 : qs[63:0];
            OP_FIT:
            begin
                ea0_reg <= v0a_reg[31:0];
                eb0_reg <= v0b_reg[31:0];
                ea1_reg <= v1a_reg[31:0];
                eb1_reg <= v1b_reg[31:0];
            end
            OP_M0: m0_reg <= mbig;
            OP_M1: m1_reg <= mbig;
            OP_SWP:
            begin
                if (m0_reg > m1_reg)
                begin
                    ea0_reg <= ea1_reg;
                    eb0_reg <= eb1_reg;
                    ea1_reg <= ea0_reg;
                    eb1_reg <= eb0_reg;
                    m1_reg  <= m0_reg;
                end
            end
            OP_JPRE:
            begin
                logi_reg <= logi_c;
                half_reg <= (logi_c == '0) ? JW'(0) : JW'(JW'(1) << (logi_c - 1'b1));
                pn_reg   <= mm_p;
            end
            OP_JP2:
            begin
                p_reg <= (logi_reg == '0) ? PW'(0) : PW'(PW'(pn_reg) << (logi_reg - 1'b1));
            end
            OP_LINES:
            begin
                lines_reg <= LINES_W'(LINES_W'((tc_reg == 7'd0) ? 7'd1 : tc_reg)
                             << (LOGI_W'(LOG_REGION) - logi_reg));
            end
            OP_JMUL:
            begin
                h_reg <= (prod2 > PR_W'(SH_MAX)) ? SH_MAX : prod2[SH_W-1:0];
            end
            OP_OUT:
            begin
                fa_reg <= ovf_reg ? 32'd0 : ea0_reg;
                fb_reg <= ovf_reg ? 32'd0 : eb0_reg;
                sa_reg <= ovf_reg ? 32'd0 : ea1_reg;
                sb_reg <= ovf_reg ? 32'd0 : eb1_reg;
                sh_reg <= (ovf_reg || j_reg == '0) ? SH_W'(0) : h_reg;
                of_reg <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign st.busy     = mul_busy | div_busy;
    assign st.done     = mul_done | div_done;
    assign st.stop     = stop_reg;
    assign st.ovf      = ovf_reg;
    assign st.scale    = scale_reg;
    assign st.jpos     = j_reg != '0;
    assign st.out_busy = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign first_a      = fa_reg;
    assign first_b      = fb_reg;
    assign second_a     = sa_reg;
    assign second_b     = sb_reg;
    assign sieve_height = sh_reg;
    assign overflow     = of_reg;

endmodule

// ----- rtl/core/sglr_ctrl.sv -----
module sglr_ctrl
    import sglr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  st_t  st,
    output cmd_t cmd
);

    typedef enum logic [25:0] {
        S_IDLE  = 26'd1,        S_N_AA  = 26'd2,        S_N_BB  = 26'd4,
        S_N_TS  = 26'd8,        S_D_AA  = 26'd16,       S_D_BB  = 26'd32,
        S_D_TS  = 26'd64,       S_DIVQ  = 26'd128,      S_RND1  = 26'd256,
        S_RND2  = 26'd512,      S_CHK   = 26'd1024,     S_U_A   = 26'd2048,
        S_U_B   = 26'd4096,     S_NEXT  = 26'd8192,     S_FIT   = 26'd16384,
        S_M0    = 26'd32768,    S_M1    = 26'd65536,    S_SWP   = 26'd131072,
        S_JPRE  = 26'd262144,   S_JP2   = 26'd524288,   S_DIVJ  = 26'd1048576,
        S_JQ    = 26'd2097152,  S_LINES = 26'd4194304,  S_DIVL  = 26'd8388608,
        S_JMUL  = 26'd16777216, S_OUT   = 26'd33554432
    } state_t;

    state_t            state_reg, state_next;
    logic              issued_reg, issued_next;
    logic              dir_reg, dir_next;
    logic [RC_W-1:0]   rnd_reg, rnd_next;
    op_t               op;
    op_t               wop;
    state_t            wnext;
    logic              waiting;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            dir_reg    <= 1'b0;
            rnd_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            dir_reg    <= dir_next;
            rnd_reg    <= rnd_next;
        end
    end

    always_comb
    begin
        waiting = 1'b1;
        wop     = OP_NONE;
        wnext   = S_IDLE;
        unique case (state_reg)
            S_N_AA:  begin wop = OP_MUL_AA;  wnext = S_N_BB; end
            S_N_BB:  begin wop = OP_MUL_BB;  wnext = S_N_TS; end
            S_N_TS:  begin wop = OP_MUL_TSN; wnext = S_D_AA; end
            S_D_AA:  begin wop = OP_MUL_VAA; wnext = S_D_BB; end
            S_D_BB:  begin wop = OP_MUL_VBB; wnext = S_D_TS; end
            S_D_TS:  begin wop = OP_MUL_TSD; wnext = S_DIVQ; end
            S_DIVQ:  begin wop = OP_DIV_Q;   wnext = S_RND1; end
            S_U_A:   begin wop = OP_MUL_KA;  wnext = S_U_B;  end
            S_U_B:   begin wop = OP_MUL_KB;  wnext = S_NEXT; end
            S_DIVJ:  begin wop = OP_DIV_J;   wnext = S_JQ;   end
            S_DIVL:  begin wop = OP_DIV_L;   wnext = S_JMUL; end
            default: waiting = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        dir_next    = dir_reg;
        rnd_next    = rnd_reg;
        op          = OP_NONE;
        in_ready    = 1'b0;
        if (waiting)
        begin
            if (!issued_reg)
            begin
                op          = wop;
                issued_next = 1'b1;
            end
            else if (st.done)
            begin
                issued_next = 1'b0;
                state_next  = wnext;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        op         = OP_LOAD;
                        dir_next   = 1'b0;
                        rnd_next   = '0;
                        state_next = S_N_AA;
                    end
                end
                S_RND1: begin op = OP_RND1; state_next = S_RND2; end
                S_RND2: begin op = OP_RND2; state_next = S_CHK;  end
                S_CHK:  state_next = st.stop ? S_FIT : S_U_A;
                S_NEXT:
                begin
                    if (st.ovf)
                    begin
                        state_next = S_FIT;
                    end
                    else if (dir_reg)
                    begin
                        if (rnd_reg == RC_W'(MAX_ROUNDS - 1))
                        begin
                            state_next = S_FIT;
                        end
                        else
                        begin
                            rnd_next   = RC_W'(rnd_reg + 1'b1);
                            dir_next   = 1'b0;
                            state_next = S_N_AA;
                        end
                    end
                    else
                    begin
                        dir_next   = 1'b1;
                        state_next = S_N_AA;
                    end
                end
                S_FIT:  begin op = OP_FIT;  state_next = S_M0;   end
                S_M0:   begin op = OP_M0;   state_next = S_M1;   end
                S_M1:   begin op = OP_M1;   state_next = S_SWP;  end
                S_SWP:  begin op = OP_SWP;  state_next = S_JPRE; end
                S_JPRE: begin op = OP_JPRE; state_next = S_JP2;  end
                S_JP2:
                begin
                    op         = OP_JP2;
                    state_next = st.scale ? S_DIVJ : S_LINES;
                end
                S_JQ:   begin op = OP_JQ;   state_next = S_LINES; end
                S_LINES:
                begin
                    op         = OP_LINES;
                    state_next = st.jpos ? S_DIVL : S_OUT;
                end
                S_JMUL: begin op = OP_JMUL; state_next = S_OUT; end
                S_OUT:
                begin
                    if (!st.out_busy)
                    begin
                        op         = OP_OUT;
                        state_next = S_IDLE;
                    end
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    assign cmd.op  = op;
    assign cmd.dir = dir_reg;

endmodule

// ----- rtl/core/skewed_gauss_lattice_reduce_core.sv -----
// Skewed Gauss reduction of the special-q lattice (q,0),(rho,1).
// Input channel: in_valid/in_ready carry special_q and root_rho; one request
// is taken only while the core is idle.
// Output channel: out_valid/out_ready carry the reduced pair, the sieve
// height and the overflow flag; one result per request.
// Config channel: cfg_valid/cfg_ready with cfg_index 0..3 selecting skewness,
// norm bound, log sieve width and thread count; always ready, write when idle.
// Sequence: each Gauss half step runs six shift-add multiplies (one bit of the
// multiplier per cycle), a restoring divide and two more multiplies; a request
// needs at most 2*MAX_ROUNDS half steps. The sieve height adds up to two
// further divides. The core works on one request at a time and takes the next
// only once the previous result is in the output register.
// A finished result sits in the output register while the next request is
// already taken; a stalled receiver holds the core only at the hand-over of
// the following result.
// Reset loads the default configuration and drops any request in flight.
module skewed_gauss_lattice_reduce_core
    import sglr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [52:0]        special_q,
    input  logic [52:0]        root_rho,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] first_a,
    output logic signed [31:0] first_b,
    output logic signed [31:0] second_a,
    output logic signed [31:0] second_b,
    output logic [SH_W-1:0]    sieve_height,
    output logic               overflow
);

`include "skewed_gauss_lattice_reduce_core_macros.svh"

    cmd_t cmd;
    st_t  st;

    assign cfg_ready = 1'b1;

    sglr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    sglr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .special_q    (special_q),
        .root_rho     (root_rho),
        .cmd          (cmd),
        .st           (st),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .first_a      (first_a),
        .first_b      (first_b),
        .second_a     (second_a),
        .second_b     (second_b),
        .sieve_height (sieve_height),
        .overflow     (overflow)
    );

    `SGLR_ASSERT(a_idle_units, in_ready |-> !st.busy, "request taken while a unit is busy")
    `SGLR_ASSERT(a_out_free, (cmd.op == OP_OUT) |-> !st.out_busy, "result overwritten")
    `SGLR_ASSERT_NEVER(a_done_idle, st.done && in_ready, "unit finished while idle")

endmodule

// ----- tb/tb_skewed_gauss_lattice_reduce_core.sv -----
module tb_skewed_gauss_lattice_reduce_core
    import sglr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [255:0] wide_t;

    typedef struct packed {
        logic [52:0] q;
        logic [52:0] rho;
    } lattice_req_t;

    typedef struct packed {
        logic [31:0]     fa;
        logic [31:0]     fb;
        logic [31:0]     sa;
        logic [31:0]     sb;
        logic [SH_W-1:0] sh;
        logic            ovf;
    } reduced_t;

    localparam longint CYCLE_LIMIT = 64'd2_000_000_000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [52:0]        special_q;
    logic [52:0]        root_rho;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] first_a;
    logic signed [31:0] first_b;
    logic signed [31:0] second_a;
    logic signed [31:0] second_b;
    logic [SH_W-1:0]    sieve_height;
    logic               overflow;

    logic [31:0] skew_cfg;
    logic [31:0] bound_cfg;
    logic [4:0]  logi_cfg;
    logic [6:0]  threads_cfg;

    lattice_req_t pending_reqs[$];
    reduced_t     expected_reductions[$];
    int           mismatches;
    int           received;
    int           req_gap;
    int           resp_gap;
    int           hold_left;
    bit           hold_done;
    bit           no_idle;
    longint       cycles;
    reduced_t     got;

    skewed_gauss_lattice_reduce_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .special_q    (special_q),
        .root_rho     (root_rho),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_a      (first_a),
        .first_b      (first_b),
        .second_a     (second_a),
        .second_b     (second_b),
        .sieve_height (sieve_height),
        .overflow     (overflow)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit wide_fits(input wide_t x, input int bits);
        wide_t h;
        h = $signed(x) >>> (bits - 1);
        return (&h) || (~|h);
    endfunction

    function automatic wide_t skew_dot(input wide_t ua, ub, va, vb, ss);
        return ((ua * va) << 32) + ub * vb * ss;
    endfunction

    function automatic bit nearest_quot(input wide_t num, den, output logic [63:0] k);
        wide_t m;
        wide_t qt;
        wide_t r;
        bit    neg;
        k = '0;
        if (den == '0 || den[255])
            return 1'b1;
        neg = num[255];
        m = neg ? -num : num;
        qt = m / den;
        r = (m % den) << 1;
        if (r > den || (r == den && qt[0]))
            qt = qt + 1;
        if (neg)
            qt = -qt;
        if (!wide_fits(qt, 64))
            return 1'b0;
        k = qt[63:0];
        return 1'b1;
    endfunction

    function automatic bit size_reduce(inout wide_t ua, ub, input wide_t va, vb, ss,
                                       inout bit ovf);
        logic [63:0] k;
        wide_t       kw;
        if (!nearest_quot(skew_dot(ua, ub, va, vb, ss), skew_dot(va, vb, va, vb, ss), k))
        begin
            ovf = 1'b1;
            return 1'b0;
        end
        if (k == '0)
            return 1'b0;
        kw = {{192{k[63]}}, k};
        ua = ua - kw * va;
        ub = ub - kw * vb;
        if (!wide_fits(ua, 80) || !wide_fits(ub, 80))
        begin
            ovf = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] abs64(input logic [63:0] x);
        return x[63] ? -x : x;
    endfunction

    function automatic reduced_t reduce_lattice(input lattice_req_t req);
        reduced_t    res;
        wide_t       v0a, v0b, v1a, v1b, sw, ss, p, qt;
        bit          ovf;
        logic [63:0] e0, e1, e2, e3, t0, t1, m0, m1, half, j, lines, logi;
        res = '0;
        ovf = 1'b0;
        v0a = {203'd0, req.q};
        v0b = '0;
        v1a = {203'd0, req.rho};
        v1b = 256'd1;
        sw  = {224'd0, skew_cfg};
        ss  = sw * sw;
        for (int rnd = 0; rnd < MAX_ROUNDS; rnd++)
        begin
            if (!size_reduce(v0a, v0b, v1a, v1b, ss, ovf))
                break;
            if (!size_reduce(v1a, v1b, v0a, v0b, ss, ovf))
                break;
        end
        if (!ovf)
            ovf = !(wide_fits(v0a, 32) && wide_fits(v0b, 32) &&
                    wide_fits(v1a, 32) && wide_fits(v1b, 32));
        if (ovf)
        begin
            res.ovf = 1'b1;
            return res;
        end
        e0 = v0a[63:0];
        e1 = v0b[63:0];
        e2 = v1a[63:0];
        e3 = v1b[63:0];
        m0 = abs64(e0) << 16;
        t0 = abs64(e1) * {32'd0, skew_cfg};
        if (t0 > m0)
            m0 = t0;
        m1 = abs64(e2) << 16;
        t1 = abs64(e3) * {32'd0, skew_cfg};
        if (t1 > m1)
            m1 = t1;
        if (m0 > m1)
        begin
            t0 = e0;
            t1 = e1;
            e0 = e2;
            e1 = e3;
            e2 = t0;
            e3 = t1;
            m1 = m0;
        end
        logi = (logi_cfg > LOG_REGION) ? 64'(LOG_REGION) : {59'd0, logi_cfg};
        half = (logi == 0) ? 64'd0 : (64'd1 << (logi - 1));
        j = half;
        if (m1 != 0 && m1 >= ({32'd0, bound_cfg} << 16))
        begin
            p  = {224'd0, bound_cfg} * sw * {192'd0, half};
            qt = p / {192'd0, m1};
            j  = qt[63:0];
            if (j > half)
                j = half;
        end
        lines = (64'd1 << (LOG_REGION - logi)) *
                ((threads_cfg == 0) ? 64'd1 : {57'd0, threads_cfg});
        if (j > 0)
            j = ((j - 1) / lines + 1) * lines;
        if (j > 64'd8388607)
            j = 64'd8388607;
        res.fa = e0[31:0];
        res.fb = e1[31:0];
        res.sa = e2[31:0];
        res.sb = e3[31:0];
        res.sh = j[SH_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [52:0] rand53();
        return {21'($urandom_range(0, 2097151)), $urandom()};
    endfunction

    function automatic lattice_req_t random_req();
        lattice_req_t req;
        int           r;
        int           bits;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            bits = $urandom_range(2, 16);
            req.q = (rand53() & ((53'd1 << bits) - 1)) | 53'd2;
            req.rho = rand53() % req.q;
        end
        else if (r < 95)
        begin
            req.q = rand53() | 53'd2;
            req.rho = rand53() % req.q;
        end
        else
        begin
            req.q = rand53();
            req.rho = rand53();
        end
        return req;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            special_q <= '0;
            root_rho  <= '0;
            req_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_reductions.push_back(reduce_lattice('{special_q, root_rho}));
            if (!in_valid || in_ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap  <= req_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    special_q <= pending_reqs[0].q;
                    root_rho  <= pending_reqs[0].rho;
                    void'(pending_reqs.pop_front());
                    in_valid  <= 1'b1;
                    req_gap   <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            resp_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
            received  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                received <= received + 1;
                got = '{first_a, first_b, second_a, second_b, sieve_height, overflow};
                if (expected_reductions.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    if (got.fa !== expected_reductions[0].fa ||
                        got.fb !== expected_reductions[0].fb ||
                        got.sa !== expected_reductions[0].sa ||
                        got.sb !== expected_reductions[0].sb ||
                        got.sh !== expected_reductions[0].sh ||
                        got.ovf !== expected_reductions[0].ovf)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p actual %p",
                                     expected_reductions[0], got);
                    end
                    void'(expected_reductions.pop_front());
                end
            end
            if (!hold_done && received == 4)
            begin
                hold_done <= 1'b1;
                hold_left <= 40000;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (resp_gap > 0)
            begin
                resp_gap  <= resp_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                resp_gap  <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("skewed_gauss_lattice_reduce_core verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SKEW:    skew_cfg    = val;
            CFG_BOUND:   bound_cfg   = val;
            CFG_LOGI:    logi_cfg    = val[4:0];
            CFG_THREADS: threads_cfg = val[6:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_reqs.size() > 0 || in_valid || expected_reductions.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] s, b, input logic [31:0] li, th);
        wait_drained();
        write_reg(CFG_SKEW, s);
        write_reg(CFG_BOUND, b);
        write_reg(CFG_LOGI, li);
        write_reg(CFG_THREADS, th);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_reqs.push_back(random_req());
    endtask

    localparam logic [52:0] Q_MAX = {53{1'b1}};

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SKEW;
        cfg_data    = '0;
        in_valid    = 1'b0;
        special_q   = '0;
        root_rho    = '0;
        out_ready   = 1'b0;
        mismatches  = 0;
        cycles      = 0;
        no_idle     = 1'b0;
        skew_cfg    = 32'd65536;
        bound_cfg   = 32'd1048576;
        logi_cfg    = 5'd11;
        threads_cfg = 7'd1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_reqs.push_back('{53'd2, 53'd0});
        pending_reqs.push_back('{53'd2, 53'd1});
        pending_reqs.push_back('{53'd0, 53'd0});
        pending_reqs.push_back('{53'd1, 53'd1});
        pending_reqs.push_back('{Q_MAX, Q_MAX});
        pending_reqs.push_back('{Q_MAX, 53'd0});
        pending_reqs.push_back('{Q_MAX, 53'd1});
        pending_reqs.push_back('{Q_MAX, Q_MAX - 1});
        pending_reqs.push_back('{53'd9007199254740881, 53'd3141592653589793});
        pending_reqs.push_back('{53'd1000003, 53'd500001});
        pending_reqs.push_back('{53'd17, Q_MAX});
        pending_reqs.push_back('{53'h0AAAAAAAAAAAAA, 53'h15555555555555});
        queue_random(120);

        configure(32'd1, 32'd1, 32'd1, 32'd1);
        pending_reqs.push_back('{Q_MAX, 53'd12345});
        queue_random(150);

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16, 32'd64);
        pending_reqs.push_back('{Q_MAX, 53'd777});
        queue_random(150);

        configure(32'd0, 32'd0, 32'd0, 32'd0);
        pending_reqs.push_back('{53'd101, 53'd7});
        queue_random(120);

        configure(32'd196608, 32'd1000, 32'd31, 32'd127);
        queue_random(150);

        no_idle = 1'b1;
        configure(32'd65536, 32'd1, 32'd8, 32'd3);
        queue_random(150);
        no_idle = 1'b0;

        for (int ph = 0; ph < 5; ph++)
        begin
            configure($urandom(), $urandom_range(0, 3) == 0 ? $urandom() :
                      $urandom_range(1, 5000), $urandom_range(0, 31),
                      $urandom_range(0, 127));
            queue_random(130);
        end

        wait_drained();
        repeat (2000) @(posedge clk);
        if (mismatches == 0 && expected_reductions.size() == 0)
            $display("skewed_gauss_lattice_reduce_core verification clean");
        else
            $display("skewed_gauss_lattice_reduce_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sglr_pkg.sv
rtl/core/sglr_mul.sv
rtl/core/sglr_div.sv
rtl/core/sglr_dp.sv
rtl/core/sglr_ctrl.sv
rtl/core/skewed_gauss_lattice_reduce_core.sv
tb/tb_skewed_gauss_lattice_reduce_core.sv
